// File: hw/rtl/ubab_pkg.sv
`timescale 1ns / 1ps
package ubab_pkg;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_ECHO,
      PH_RD_HI,
      PH_RD_LO,
      PH_WR_HI,
      PH_WR_LO,
      PH_WR_VAL,
      PH_SR_ADDR,
      PH_SW_ADDR,
      PH_SW_VAL,
      PH_ACK_MASK,
      PH_WAIT_MEM,
      PH_WAIT_SFR
   } phase_type;

   localparam logic [1:0] OP_BYTE    = 2'd0;
   localparam logic [1:0] OP_INT     = 2'd1;
   localparam logic [1:0] OP_MEM_RET = 2'd2;
   localparam logic [1:0] OP_SFR_RET = 2'd3;

   localparam logic [2:0] KIND_TX     = 3'd0;
   localparam logic [2:0] KIND_MEM_RD = 3'd1;
   localparam logic [2:0] KIND_MEM_WR = 3'd2;
   localparam logic [2:0] KIND_SFR_RD = 3'd3;
   localparam logic [2:0] KIND_SFR_WR = 3'd4;

   localparam logic [7:0] CMD_LOOPBACK  = 8'h00;
   localparam logic [7:0] CMD_MEM_RD    = 8'h01;
   localparam logic [7:0] CMD_MEM_WR    = 8'h02;
   localparam logic [7:0] CMD_SFR_RD    = 8'h03;
   localparam logic [7:0] CMD_SFR_WR    = 8'h04;
   localparam logic [7:0] CMD_IRQ_CLEAR = 8'h05;

   localparam logic [15:0] WIN_LO       = 16'hC000;
   localparam logic [15:0] WIN_HI       = 16'hC00F;
   localparam logic [15:0] WIN_ID_ADDR  = 16'hC009;
   localparam logic [7:0]  WIN_ID_VALUE = 8'h60;
   localparam logic [15:0] SHADOW_ADDR  = 16'h00A8;
   localparam logic [7:0]  NOTE_BYTE    = 8'h7E;
   localparam logic [7:0]  ACK_BYTE     = 8'h00;
   localparam logic [7:0]  UNKNOWN_BYTE = 8'h3F;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] payload;
      logic [5:0] int_sources;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  byte_value;
      logic [15:0] bus_address;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        has_bus;
      logic [2:0]  bus_kind;
      logic [7:0]  bus_value;
      logic [15:0] bus_addr;
      logic        has_reply;
      logic [7:0]  reply0;
      logic [7:0]  reply1;
      logic        has_note;
      logic [5:0]  note_mask;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_out_type;

endpackage

// File: hw/rtl/uart_bus_access_bridge_top.sv
`timescale 1ns / 1ps
// UART command bridge. Each request transfer (received byte, interrupt
// sources or bus read return) is taken by the command parser, which turns
// it into a job of up to five response transfers (bus request, two reply
// bytes, two interrupt notice bytes) and queues it in a QUEUE_DEPTH-entry
// job queue. The response side emits one transfer per cycle from a
// registered output while rsp_stall does not hold it, sending each job's
// transfers in turn: none for parser-only bytes, up to five for a memory
// write with an interrupt notice. req_stall rises only while the job
// queue is full. Results come out in request order.
module uart_bus_access_bridge_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ubab_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ubab_pkg::rsp_type rsp_data
);
   import ubab_pkg::*;

   logic          accept;
   logic          push;
   job_type       push_job;
   logic          full;
   logic          pop;
   queue_out_type head;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   ubab_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .push     (push),
      .push_job (push_job)
   );

   ubab_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .head     (head)
   );

   ubab_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hw/rtl/ubab_front.sv
`timescale 1ns / 1ps
module ubab_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  ubab_pkg::req_type req,
   output logic              push,
   output ubab_pkg::job_type push_job
);
   import ubab_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] addr_ff, addr_in;
   logic [5:0]  pend_ff, pend_in;
   logic [5:0]  sent_ff, sent_in;
   logic [7:0]  shadow_ff, shadow_in;
   job_type     job;
   logic        fin;
   logic [5:0]  fresh;
   logic [15:0] lo_addr;
   logic [7:0]  b;

   function automatic logic in_window(input logic [15:0] a);
      in_window = (a >= WIN_LO) && (a <= WIN_HI);
   endfunction

   function automatic logic sfr_listed(input logic [7:0] a);
      case (a)
         8'hB8, 8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D,
         8'hD0, 8'hE0, 8'hF0, 8'h81, 8'h82, 8'h83, 8'h87: sfr_listed = 1'b1;
         default: sfr_listed = 1'b0;
      endcase
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         addr_ff   <= '0;
         pend_ff   <= '0;
         sent_ff   <= '0;
         shadow_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         addr_ff   <= addr_in;
         pend_ff   <= pend_in;
         sent_ff   <= sent_in;
         shadow_ff <= shadow_in;
      end
   end

   always_comb begin
      b         = req.payload;
      lo_addr   = {addr_ff[15:8], b};
      phase_in  = phase_ff;
      addr_in   = addr_ff;
      pend_in   = pend_ff;
      sent_in   = sent_ff;
      shadow_in = shadow_ff;
      job       = '0;
      fin       = 1'b0;
      fresh     = '0;
      if (accept) begin
         case (req.opcode)
            OP_BYTE: begin
               unique case (phase_ff)
                  PH_ECHO: begin
                     job.has_reply = 1'b1;
                     job.reply0    = b;
                     job.reply1    = ~b;
                     fin           = 1'b1;
                  end
                  PH_RD_HI: begin
                     addr_in  = {b, 8'h00};
                     phase_in = PH_RD_LO;
                  end
                  PH_RD_LO: begin
                     addr_in = lo_addr;
                     if (in_window(lo_addr)) begin
                        job.has_reply = 1'b1;
                        job.reply0    = (lo_addr == WIN_ID_ADDR) ? WIN_ID_VALUE : 8'h00;
                        job.reply1    = ~job.reply0;
                        fin           = 1'b1;
                     end else begin
                        job.has_bus  = 1'b1;
                        job.bus_kind = KIND_MEM_RD;
                        job.bus_addr = lo_addr;
                        phase_in     = PH_WAIT_MEM;
                     end
                  end
                  PH_WR_HI: begin
                     addr_in  = {b, 8'h00};
                     phase_in = PH_WR_LO;
                  end
                  PH_WR_LO: begin
                     addr_in  = lo_addr;
                     phase_in = PH_WR_VAL;
                  end
                  PH_WR_VAL: begin
                     if (!in_window(addr_ff)) begin
                        job.has_bus   = 1'b1;
                        job.bus_kind  = KIND_MEM_WR;
                        job.bus_value = b;
                        job.bus_addr  = addr_ff;
                     end
                     job.has_reply = 1'b1;
                     job.reply0    = ACK_BYTE;
                     job.reply1    = ~ACK_BYTE;
                     fin           = 1'b1;
                  end
                  PH_SR_ADDR: begin
                     addr_in = {8'h00, b};
                     if ({8'h00, b} == SHADOW_ADDR) begin
                        job.has_reply = 1'b1;
                        job.reply0    = shadow_ff;
                        job.reply1    = ~shadow_ff;
                        fin           = 1'b1;
                     end else if (sfr_listed(b)) begin
                        job.has_bus  = 1'b1;
                        job.bus_kind = KIND_SFR_RD;
                        job.bus_addr = {8'h00, b};
                        phase_in     = PH_WAIT_SFR;
                     end else begin
                        job.has_reply = 1'b1;
                        job.reply0    = 8'h00;
                        job.reply1    = 8'hFF;
                        fin           = 1'b1;
                     end
                  end
                  PH_SW_ADDR: begin
                     addr_in  = {8'h00, b};
                     phase_in = PH_SW_VAL;
                  end
                  PH_SW_VAL: begin
                     if (addr_ff == SHADOW_ADDR) begin
                        shadow_in = b;
                     end else if (sfr_listed(addr_ff[7:0])) begin
                        job.has_bus   = 1'b1;
                        job.bus_kind  = KIND_SFR_WR;
                        job.bus_value = b;
                        job.bus_addr  = addr_ff;
                     end
                     job.has_reply = 1'b1;
                     job.reply0    = ACK_BYTE;
                     job.reply1    = ~ACK_BYTE;
                     fin           = 1'b1;
                  end
                  PH_ACK_MASK: begin
                     sent_in       = sent_ff & ~b[5:0];
                     pend_in       = pend_ff & ~b[5:0];
                     job.has_reply = 1'b1;
                     job.reply0    = ACK_BYTE;
                     job.reply1    = ~ACK_BYTE;
                     fin           = 1'b1;
                  end
                  PH_WAIT_MEM, PH_WAIT_SFR: begin
                  end
                  default: begin
                     unique case (b)
                        CMD_LOOPBACK:  phase_in = PH_ECHO;
                        CMD_MEM_RD:    phase_in = PH_RD_HI;
                        CMD_MEM_WR:    phase_in = PH_WR_HI;
                        CMD_SFR_RD:    phase_in = PH_SR_ADDR;
                        CMD_SFR_WR:    phase_in = PH_SW_ADDR;
                        CMD_IRQ_CLEAR: phase_in = PH_ACK_MASK;
                        default: begin
                           job.has_reply = 1'b1;
                           job.reply0    = UNKNOWN_BYTE;
                           job.reply1    = UNKNOWN_BYTE;
                           fin           = 1'b1;
                        end
                     endcase
                  end
               endcase
            end
            OP_INT: begin
               if (phase_ff == PH_IDLE) begin
                  pend_in = pend_ff | (req.int_sources & shadow_ff[5:0] & ~sent_ff);
               end
            end
            OP_MEM_RET: begin
               if (phase_ff == PH_WAIT_MEM) begin
                  job.has_reply = 1'b1;
                  job.reply0    = b;
                  job.reply1    = ~b;
                  fin           = 1'b1;
               end
            end
            default: begin
               if (phase_ff == PH_WAIT_SFR) begin
                  job.has_reply = 1'b1;
                  job.reply0    = b;
                  job.reply1    = ~b;
                  fin           = 1'b1;
               end
            end
         endcase
         if (fin) begin
            fresh    = pend_in & ~sent_in;
            phase_in = PH_IDLE;
            if (fresh != 6'd0) begin
               sent_in       = sent_in | fresh;
               job.has_note  = 1'b1;
               job.note_mask = fresh;
            end
         end
      end
      push     = job.has_bus || job.has_reply;
      push_job = job;
   end

endmodule

// File: hw/rtl/ubab_queue.sv
`timescale 1ns / 1ps
module ubab_queue #(
   parameter int DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ubab_pkg::job_type       push_job,
   output logic                    full,
   input  logic                    pop,
   output ubab_pkg::queue_out_type head
);
   import ubab_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type         mem [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
      head.valid = (count_ff != '0);
      head.job   = mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: hw/rtl/ubab_back.sv
`timescale 1ns / 1ps
module ubab_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ubab_pkg::queue_out_type head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output ubab_pkg::rsp_type       rsp_data
);
   import ubab_pkg::*;

   job_type    cur_ff, cur_in;
   logic [4:0] rem_ff, rem_in;
   logic [4:0] pick;
   logic [4:0] rem_next;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   rsp_type    item;
   logic       out_free;
   logic       emit;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      emit     = out_free && (rem_ff != 5'd0);
      pick     = rem_ff & (~rem_ff + 5'd1);
      rem_next = rem_ff & ~pick;

      item             = '0;
      item.kind        = KIND_TX;
      item.last        = (rem_next == 5'd0);
      if (pick[0]) begin
         item.kind        = cur_ff.bus_kind;
         item.byte_value  = cur_ff.bus_value;
         item.bus_address = cur_ff.bus_addr;
      end else if (pick[1]) begin
         item.byte_value = cur_ff.reply0;
      end else if (pick[2]) begin
         item.byte_value = cur_ff.reply1;
      end else if (pick[3]) begin
         item.byte_value = NOTE_BYTE;
      end else begin
         item.byte_value = {2'b00, cur_ff.note_mask};
      end

      pop = head.valid && ((rem_ff == 5'd0) || (emit && rem_next == 5'd0));

      cur_in = cur_ff;
      rem_in = rem_ff;
      if (pop) begin
         cur_in = head.job;
         rem_in = {head.job.has_note, head.job.has_note, head.job.has_reply,
                   head.job.has_reply, head.job.has_bus};
      end else if (emit) begin
         rem_in = rem_next;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = emit;
         rsp_in       = item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: hw/rtl/ubab_checker.sv
`timescale 1ns / 1ps
module ubab_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input ubab_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ubab_pkg::rsp_type rsp_data
);
   import ubab_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_tx_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_TX |-> rsp_data.bus_address == 16'h0000)
      else $error("transmit byte carries an address");

   a_read_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_MEM_RD || rsp_data.kind == KIND_SFR_RD)
      |-> rsp_data.byte_value == 8'h00 && rsp_data.last)
      else $error("read request not a lone final transfer");

   a_write_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall &&
      (rsp_data.kind == KIND_MEM_WR || rsp_data.kind == KIND_SFR_WR)
      |=> rsp_valid && rsp_data.kind == KIND_TX && rsp_data.byte_value == ACK_BYTE)
      else $error("write request not followed by acknowledge");

endmodule

bind uart_bus_access_bridge_top ubab_checker u_ubab_checker (.*);
